### hdl/assert_macros.svh
// assertion macros used by the top-level core file
// no dependencies; define ASSERT_OFF to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

### hdl/dnp_pkg.sv
// shared types and constants for the dns name to presentation core
// no dependencies
`default_nettype none
package dnp_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] PRINT_LO = 8'h21;
  localparam logic [7:0] PRINT_HI = 8'h7E;

  // what the back end has to emit for one input byte
  typedef enum logic [1:0] {
    K_DOT   = 2'd0,  // '.', one character
    K_PLAIN = 2'd1,  // the byte itself
    K_ESC   = 2'd2,  // backslash then the byte
    K_DEC   = 2'd3   // backslash then three decimal digits
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] byt;
    logic       fin;   // dot closes the whole name
  } cmd_t;

endpackage
`default_nettype wire

### hdl/dnp_front.sv
// front end: accepts wire bytes, tracks label position, emits commands
// depends on dnp_pkg
`default_nettype none
module dnp_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_wire_byte,
  input  wire logic          q_full,
  output logic               push,
  output dnp_pkg::cmd_t      push_cmd
);

  logic       at_start_r, at_start_nxt;
  logic [7:0] remain_r, remain_nxt;
  logic       has_out;
  logic       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && has_out;

  always_comb begin
    at_start_nxt  = at_start_r;
    remain_nxt    = remain_r;
    has_out       = 1'b1;
    push_cmd.kind = dnp_pkg::K_DOT;
    push_cmd.byt  = in_wire_byte;
    push_cmd.fin  = 1'b0;
    if (at_start_r) begin
      if (in_wire_byte == 8'd0) begin
        push_cmd.fin = 1'b1;
      end else begin
        has_out      = 1'b0;
        remain_nxt   = in_wire_byte;
        at_start_nxt = 1'b0;
      end
    end else if (remain_r != 8'd0) begin
      if (in_wire_byte == dnp_pkg::CH_DOT || in_wire_byte == dnp_pkg::CH_SEMI ||
          in_wire_byte == dnp_pkg::CH_LPAR || in_wire_byte == dnp_pkg::CH_RPAR ||
          in_wire_byte == dnp_pkg::CH_BSL) begin
        push_cmd.kind = dnp_pkg::K_ESC;
      end else if (in_wire_byte < dnp_pkg::PRINT_LO || in_wire_byte > dnp_pkg::PRINT_HI) begin
        push_cmd.kind = dnp_pkg::K_DEC;
      end else begin
        push_cmd.kind = dnp_pkg::K_PLAIN;
      end
      remain_nxt = remain_r - 8'd1;
    end else begin
      // length byte after a label closes it with a dot
      if (in_wire_byte == 8'd0) begin
        push_cmd.fin = 1'b1;
        at_start_nxt = 1'b1;
      end else begin
        remain_nxt = in_wire_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_start_r <= 1'b1;
      remain_r   <= 8'd0;
    end else if (accept) begin
      at_start_r <= at_start_nxt;
      remain_r   <= remain_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/dnp_queue.sv
// small command queue between front and back end
// depends on dnp_pkg
`default_nettype none
module dnp_queue #(
  parameter int DEPTH = dnp_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire dnp_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output dnp_pkg::cmd_t      head_cmd,
  output logic               empty,
  output logic               full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dnp_pkg::cmd_t mem_r [DEPTH];
  logic [AW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] count_r;

  assign empty    = (count_r == CW'(0));
  assign full     = (count_r == CW'(DEPTH));
  assign head_cmd = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
      end
      if (pop) begin
        rptr_r <= (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

### hdl/dnp_back.sv
// back end: expands one command into one to four characters
// depends on dnp_pkg
`default_nettype none
module dnp_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire dnp_pkg::cmd_t head_cmd,
  input  wire logic          q_empty,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_char,
  output logic               out_last_of_run,
  output logic               out_end_of_name
);

  dnp_pkg::cmd_t cur_r;
  logic          cur_v_r;
  logic [1:0]    idx_r;
  logic          oval_r;
  logic [7:0]    ochar_r;
  logic          olast_r, oend_r;

  logic          advance, is_last;
  logic [1:0]    last_idx;
  logic [7:0]    ch;
  logic [1:0]    hund;
  logic [7:0]    rem;
  logic [14:0]   prod;
  logic [3:0]    tens;
  logic [7:0]    units;

  always_comb begin
    unique case (cur_r.kind)
      dnp_pkg::K_DOT:   last_idx = 2'd0;
      dnp_pkg::K_PLAIN: last_idx = 2'd0;
      dnp_pkg::K_ESC:   last_idx = 2'd1;
      dnp_pkg::K_DEC:   last_idx = 2'd3;
      default:          last_idx = 2'd0;
    endcase
  end

  // decimal digits; tens via multiply by 205 and shift by 11 (exact below 100)
  always_comb begin
    if (cur_r.byt >= 8'd200) begin
      hund = 2'd2;
      rem  = cur_r.byt - 8'd200;
    end else if (cur_r.byt >= 8'd100) begin
      hund = 2'd1;
      rem  = cur_r.byt - 8'd100;
    end else begin
      hund = 2'd0;
      rem  = cur_r.byt;
    end
    prod  = 15'(rem[6:0]) * 15'd205;
    tens  = prod[14:11];
    units = rem - 8'(tens) * 8'd10;
  end

  always_comb begin
    ch = cur_r.byt;
    case (cur_r.kind)
      dnp_pkg::K_DOT:   ch = dnp_pkg::CH_DOT;
      dnp_pkg::K_PLAIN: ch = cur_r.byt;
      dnp_pkg::K_ESC:   ch = (idx_r == 2'd0) ? dnp_pkg::CH_BSL : cur_r.byt;
      dnp_pkg::K_DEC: begin
        case (idx_r)
          2'd0:    ch = dnp_pkg::CH_BSL;
          2'd1:    ch = dnp_pkg::CH_ZERO + 8'(hund);
          2'd2:    ch = dnp_pkg::CH_ZERO + 8'(tens);
          default: ch = dnp_pkg::CH_ZERO + units;
        endcase
      end
      default: ch = cur_r.byt;
    endcase
  end

  assign is_last = (idx_r == last_idx);
  assign advance = cur_v_r && (!oval_r || out_ready);
  assign pop     = !q_empty && (!cur_v_r || (advance && is_last));

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head_cmd;
    end
    if (advance) begin
      ochar_r <= ch;
      olast_r <= is_last;
      oend_r  <= (cur_r.kind == dnp_pkg::K_DOT) && cur_r.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      idx_r   <= 2'd0;
      oval_r  <= 1'b0;
    end else begin
      if (pop) begin
        cur_v_r <= 1'b1;
        idx_r   <= 2'd0;
      end else if (advance) begin
        if (is_last) begin
          cur_v_r <= 1'b0;
          idx_r   <= 2'd0;
        end else begin
          idx_r <= idx_r + 2'd1;
        end
      end
      if (advance) begin
        oval_r <= 1'b1;
      end else if (out_ready) begin
        oval_r <= 1'b0;
      end
    end
  end

  assign out_valid       = oval_r;
  assign out_char        = ochar_r;
  assign out_last_of_run = olast_r;
  assign out_end_of_name = oend_r;

endmodule
`default_nettype wire

### hdl/dns_name_to_presentation_core.sv
// dns name wire form to text form; one byte in per cycle while the queue
// is not full, one character out per cycle while it holds commands and out_ready
// is high; a byte passes queue memory, current command and output register, and
// gives 0 to 4 characters (4 for a decimal escape), queue absorbs the difference
// reset: synchronous active-low rst_n clears label state, queue and output stage
`default_nettype none
`include "assert_macros.svh"
module dns_name_to_presentation_core #(
  parameter int QUEUE_DEPTH = dnp_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_wire_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_char,
  output logic            out_last_of_run,
  output logic            out_end_of_name
);

  logic          push, pop, q_full, q_empty;
  dnp_pkg::cmd_t push_cmd, head_cmd;

  dnp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_wire_byte (in_wire_byte),
    .q_full       (q_full),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  dnp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  dnp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_cmd        (head_cmd),
    .q_empty         (q_empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char        (out_char),
    .out_last_of_run (out_last_of_run),
    .out_end_of_name (out_end_of_name)
  );

  `ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push, !q_full)
  `ASSERT_IMPLIES(a_no_underflow, clk, rst_n, pop, !q_empty)
  `ASSERT_IMPLIES(a_end_is_dot, clk, rst_n, out_valid && out_end_of_name, (out_char == dnp_pkg::CH_DOT) && out_last_of_run)
  `ASSERT_NEXT(a_push_fills, clk, rst_n, push && !pop, !q_empty)

endmodule
`default_nettype wire
